>>> sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that stays active through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/vdlp_pkg.sv
// ----------------------------------------------------------------------------
// vdlp_pkg
// Beat types, opcodes and the delta scaler of the vector display-list
// processor.
// ----------------------------------------------------------------------------
package vdlp_pkg;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EXEC  = 1'b1;

  // Opcodes above the long-vector range (0 to 9 are VCTR with local scale)
  localparam logic [3:0] OP_LABS = 4'd10;
  localparam logic [3:0] OP_HALT = 4'd11;
  localparam logic [3:0] OP_JSRL = 4'd12;
  localparam logic [3:0] OP_RTSL = 4'd13;
  localparam logic [3:0] OP_JMPL = 4'd14;
  localparam logic [3:0] OP_SVEC = 4'd15;

  // Combined scale at which a magnitude passes unshifted
  localparam logic [3:0] SCALE_UNITY = 4'd9;
  // Short-vector scale offset
  localparam logic [3:0] SVEC_SCALE_BIAS = 4'd10;
  // Global scale after reset
  localparam logic [3:0] GSCALE_RESET = 4'hF;

  typedef struct packed {
    logic        command;
    logic [11:0] start_address;
    logic [15:0] word_first;
    logic [15:0] word_second;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] next_address;
    logic        beam_on;
    logic [15:0] from_x;
    logic [15:0] from_y;
    logic [15:0] to_x;
    logic [15:0] to_y;
    logic [3:0]  intensity;
    logic        halted;
    logic        stack_fault;
  } out_beat_t;

  // Shift a sign-magnitude delta by the combined scale, then apply the sign.
  function automatic logic [15:0] scaled_delta(input logic [9:0] mag, input logic neg,
                                               input logic [3:0] scale);
    logic [15:0] m;
    if (scale >= SCALE_UNITY) begin
      m = {6'b0, mag} << (scale - SCALE_UNITY);
    end else begin
      m = {6'b0, mag} >> (SCALE_UNITY - scale);
    end
    if (neg) begin
      m = 16'(16'd0 - m);
    end
    return m;
  endfunction

endpackage

>>> sv/vector_display_list_processor.sv
// ----------------------------------------------------------------------------
// vector_display_list_processor
// Executes one vector display-list instruction per beat and reports the next
// fetch address and the traced segment.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per instruction. command = start loads the counter from
//           start_address and sets the running flag; command = execute runs
//           the two words fetched at the counter (second word used by VCTR
//           and LABS only). Execute beats that arrive while halted are ignored.
//   out_* : exactly one result beat per input beat, in order: next fetch
//           address, beam before and after, intensity, halted and stack fault.
// Pipeline: each beat passes the input register, then the result register,
//   where out_valid rises. Throughput: 1 beat per cycle while out_ready is
//   high; the decode, shift and 16-bit add lie between the input register and
//   the result register.
// Reset (rst_n low, synchronous): both stages empty, beam at the origin,
//   global scale 15, counter and stack pointer zero, processor halted.
// Stall: while out_ready is low the result register holds its beat, the
//   input register keeps one more instruction and in_ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module vector_display_list_processor #(
  parameter int STACK_DEPTH  = 4,
  parameter int ADDRESS_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vdlp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vdlp_pkg::out_beat_t out_data
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Pipeline registers
  logic                s1_valid_r;
  vdlp_pkg::in_beat_t  s1_item_r;
  logic                out_valid_r;
  vdlp_pkg::out_beat_t out_data_r;

  // Architectural state
  logic [15:0]             beam_x_r, beam_x_nxt;
  logic [15:0]             beam_y_r, beam_y_nxt;
  logic [3:0]              gscale_r, gscale_nxt;
  logic [ADDRESS_BITS-1:0] pc_r, pc_nxt;
  logic [SPW-1:0]          sp_r, sp_nxt;
  logic                    running_r, running_nxt;
  logic [ADDRESS_BITS-1:0] stack_r [STACK_DEPTH];

  logic                commit;
  logic                push_en;
  logic [3:0]          bright;
  logic                fault;
  vdlp_pkg::out_beat_t result;

  // Decode helpers
  logic [15:0]             w1, w2;
  logic [3:0]              op;
  logic                    is_svec;
  logic [1:0]              svec_ss;
  logic [3:0]              scale;
  logic [9:0]              mag_x, mag_y;
  logic                    neg_x;
  logic [15:0]             dx, dy;
  logic [ADDRESS_BITS-1:0] pc_inc1, pc_inc2;
  logic [15:0]             start_ext, target_ext, pc_ext;
  logic [ADDRESS_BITS-1:0] load_pc, target_pc;
  logic [SPW-1:0]          sp_dec;
  logic [ADDRESS_BITS-1:0] stack_top;

  // Advance the instruction when the result register is free or draining
  assign commit   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || commit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign w1      = s1_item_r.word_first;
  assign w2      = s1_item_r.word_second;
  assign op      = w1[15:12];
  assign is_svec = (op == vdlp_pkg::OP_SVEC);
  assign svec_ss = {w1[3], w1[11]};

  // One shared scaler pair serves both long and short vectors
  assign scale = is_svec ? 4'(gscale_r + {2'b00, svec_ss} + vdlp_pkg::SVEC_SCALE_BIAS)
                         : 4'(gscale_r + op);
  assign mag_y = is_svec ? {8'b0, w1[9:8]} : w1[9:0];
  assign mag_x = is_svec ? {8'b0, w1[1:0]} : w2[9:0];
  assign neg_x = is_svec ? w1[2] : w2[10];
  assign dy    = vdlp_pkg::scaled_delta(mag_y, w1[10], scale);
  assign dx    = vdlp_pkg::scaled_delta(mag_x, neg_x, scale);

  // Addresses wrap within ADDRESS_BITS
  assign pc_inc1    = pc_r + ADDRESS_BITS'(1);
  assign pc_inc2    = pc_r + ADDRESS_BITS'(2);
  assign start_ext  = {4'b0, s1_item_r.start_address};
  assign target_ext = {4'b0, w1[11:0]};
  assign load_pc    = start_ext[ADDRESS_BITS-1:0];
  assign target_pc  = target_ext[ADDRESS_BITS-1:0];

  assign sp_dec    = sp_r - SPW'(1);
  assign stack_top = stack_r[sp_dec[SIW-1:0]];

  always_comb begin
    beam_x_nxt  = beam_x_r;
    beam_y_nxt  = beam_y_r;
    gscale_nxt  = gscale_r;
    pc_nxt      = pc_r;
    sp_nxt      = sp_r;
    running_nxt = running_r;
    push_en     = 1'b0;
    bright      = 4'd0;
    fault       = 1'b0;
    if (s1_item_r.command == vdlp_pkg::CMD_START) begin
      pc_nxt      = load_pc;
      running_nxt = 1'b1;
    end else if (running_r) begin
      unique case (op)
        vdlp_pkg::OP_LABS: begin
          beam_y_nxt = {6'b0, w1[9:0]};
          beam_x_nxt = {6'b0, w2[9:0]};
          gscale_nxt = w2[15:12];
          pc_nxt     = pc_inc2;
        end
        vdlp_pkg::OP_HALT: begin
          running_nxt = 1'b0;
          pc_nxt      = pc_inc1;
        end
        vdlp_pkg::OP_JSRL: begin
          if (sp_r < SPW'(STACK_DEPTH)) begin
            push_en = 1'b1;
            sp_nxt  = sp_r + SPW'(1);
            pc_nxt  = target_pc;
          end else begin
            fault  = 1'b1;
            pc_nxt = pc_inc1;
          end
        end
        vdlp_pkg::OP_RTSL: begin
          if (sp_r != '0) begin
            sp_nxt = sp_dec;
            pc_nxt = stack_top;
          end else begin
            fault  = 1'b1;
            pc_nxt = pc_inc1;
          end
        end
        vdlp_pkg::OP_JMPL: begin
          pc_nxt = target_pc;
        end
        vdlp_pkg::OP_SVEC: begin
          beam_x_nxt = beam_x_r + dx;
          beam_y_nxt = beam_y_r + dy;
          bright     = w1[7:4];
          pc_nxt     = pc_inc1;
        end
        default: begin
          // Long vector, local scale is the opcode itself
          beam_x_nxt = beam_x_r + dx;
          beam_y_nxt = beam_y_r + dy;
          bright     = w2[15:12];
          pc_nxt     = pc_inc2;
        end
      endcase
    end
  end

  assign pc_ext = 16'(pc_nxt);

  always_comb begin
    result.next_address = pc_ext[11:0];
    result.beam_on      = (bright != 4'd0);
    result.from_x       = beam_x_r;
    result.from_y       = beam_y_r;
    result.to_x         = beam_x_nxt;
    result.to_y         = beam_y_nxt;
    result.intensity    = bright;
    result.halted       = !running_nxt;
    result.stack_fault  = fault;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (commit) begin
      out_data_r <= result;
    end
  end

  // Processor state, updated as each instruction retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_x_r  <= '0;
      beam_y_r  <= '0;
      gscale_r  <= vdlp_pkg::GSCALE_RESET;
      pc_r      <= '0;
      sp_r      <= '0;
      running_r <= 1'b0;
    end else if (commit) begin
      beam_x_r  <= beam_x_nxt;
      beam_y_r  <= beam_y_nxt;
      gscale_r  <= gscale_nxt;
      pc_r      <= pc_nxt;
      sp_r      <= sp_nxt;
      running_r <= running_nxt;
    end
  end

  // Return stack: push the return address at the stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_r[i] <= '0;
      end
    end else if (commit && push_en) begin
      stack_r[sp_r[SIW-1:0]] <= pc_inc1;
    end
  end

endmodule

>>> sv/vdlp_checker.sv
// ----------------------------------------------------------------------------
// vdlp_checker
// Port-level checks on the result channel of the display-list processor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vdlp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input vdlp_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input vdlp_pkg::out_beat_t out_data
);

  logic in_seen;
  assign in_seen = in_valid && in_ready && (in_data.command == vdlp_pkg::CMD_START);

  // A stalled result beat holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result beat changed while stalled")

  // Beam is on exactly when the segment has brightness
  `ASSERT_CLK(a_beam_on, clk, rst_n, out_valid |-> (out_data.beam_on == (out_data.intensity != 4'd0)), "beam_on disagrees with intensity")

  // A halted or faulting step traces no segment and leaves the beam in place
  `ASSERT_CLK(a_quiet_step, clk, rst_n, out_valid && (out_data.halted || out_data.stack_fault) |-> !out_data.beam_on && out_data.from_x == out_data.to_x && out_data.from_y == out_data.to_y, "halted or faulting step moved the beam")

  // Reset empties the result stage
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A start beat is accepted only through a ready input
  `ASSERT_CLK(a_start_ready, clk, rst_n, in_seen |-> in_ready, "start accepted without ready")

endmodule

bind vector_display_list_processor vdlp_checker u_vdlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/tb_vector_display_list_processor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_display_list_processor
// Drives start and instruction beats into the display-list processor and
// checks every result beat against an in-bench model of the beam, scale,
// counter and return stack. Directed cases come first, then random programs
// made mostly of well-formed instruction runs, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_vector_display_list_processor;

  localparam int STACK_DEPTH  = 4;
  localparam int ADDRESS_BITS = 12;
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_PERCENT = 10;
  localparam int DRAIN_CYCLES = 10;
  localparam int CLK_PERIOD   = 10;
  localparam int TIMEOUT_NS   = 2_000_000;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  vdlp_pkg::in_beat_t  in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  vdlp_pkg::out_beat_t out_data;

  // Suppress idling on both channels while set
  logic quiet_stretch = 1'b0;
  int unsigned error_count = 0;

  // Segments predicted for accepted beats, oldest first
  vdlp_pkg::out_beat_t expected_segments[$];

  // Model of the processor state
  logic [15:0] track_x;
  logic [15:0] track_y;
  logic [3:0]  track_scale;
  logic [11:0] track_counter;
  logic [11:0] track_returns[STACK_DEPTH];
  int unsigned track_depth;
  logic        track_running;

  vector_display_list_processor #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Put the model into the post-reset state: origin, scale 15, halted.
  task automatic clear_tracking();
    track_x       = 16'd0;
    track_y       = 16'd0;
    track_scale   = vdlp_pkg::GSCALE_RESET;
    track_counter = 12'd0;
    track_depth   = 0;
    track_running = 1'b0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      track_returns[i] = 12'd0;
    end
  endtask

  // Turn a sign-magnitude delta into a 16-bit two's complement step. The
  // combined scale moves the magnitude left above the unity point, right below.
  function automatic logic [15:0] delta_step(input logic [9:0] mag, input logic neg,
                                             input logic [3:0] scale);
    logic [15:0] step;
    step = {6'b0, mag};
    if (scale >= vdlp_pkg::SCALE_UNITY) begin
      step = step << (scale - vdlp_pkg::SCALE_UNITY);
    end else begin
      step = step >> (vdlp_pkg::SCALE_UNITY - scale);
    end
    if (neg) begin
      step = ~step + 16'd1;
    end
    return step;
  endfunction

  // Execute one beat on the model and return the segment it should report.
  function automatic vdlp_pkg::out_beat_t trace_segment(input vdlp_pkg::in_beat_t beat);
    vdlp_pkg::out_beat_t seg;
    logic [3:0]  op;
    logic [3:0]  scale;
    logic [3:0]  bright;
    logic        fault;
    logic [11:0] pc;
    seg    = '0;
    bright = 4'd0;
    fault  = 1'b0;
    pc     = track_counter;
    op     = beat.word_first[15:12];
    seg.from_x = track_x;
    seg.from_y = track_y;
    if (beat.command == vdlp_pkg::CMD_START) begin
      // Load the counter and run; beam and stack stay as they are
      track_counter = beat.start_address;
      track_running = 1'b1;
    end else if (track_running) begin
      case (op)
        vdlp_pkg::OP_LABS: begin
          // Sign bits of the coordinates are dropped
          track_y       = {6'b0, beat.word_first[9:0]};
          track_x       = {6'b0, beat.word_second[9:0]};
          track_scale   = beat.word_second[15:12];
          track_counter = pc + 12'd2;
        end
        vdlp_pkg::OP_HALT: begin
          track_running = 1'b0;
          track_counter = pc + 12'd1;
        end
        vdlp_pkg::OP_JSRL: begin
          if (track_depth < STACK_DEPTH) begin
            track_returns[track_depth] = pc + 12'd1;
            track_depth++;
            track_counter = beat.word_first[11:0];
          end else begin
            // Full stack: flag it and fall through without calling
            fault         = 1'b1;
            track_counter = pc + 12'd1;
          end
        end
        vdlp_pkg::OP_RTSL: begin
          if (track_depth > 0) begin
            track_depth--;
            track_counter = track_returns[track_depth];
          end else begin
            fault         = 1'b1;
            track_counter = pc + 12'd1;
          end
        end
        vdlp_pkg::OP_JMPL: begin
          track_counter = beat.word_first[11:0];
        end
        vdlp_pkg::OP_SVEC: begin
          scale   = track_scale + {beat.word_first[3], beat.word_first[11]}
                    + vdlp_pkg::SVEC_SCALE_BIAS;
          track_y = track_y + delta_step({8'b0, beat.word_first[9:8]}, beat.word_first[10],
                                         scale);
          track_x = track_x + delta_step({8'b0, beat.word_first[1:0]}, beat.word_first[2],
                                         scale);
          bright  = beat.word_first[7:4];
          track_counter = pc + 12'd1;
        end
        default: begin
          // Long vector, opcode is the local scale
          scale   = track_scale + op;
          track_y = track_y + delta_step(beat.word_first[9:0], beat.word_first[10], scale);
          track_x = track_x + delta_step(beat.word_second[9:0], beat.word_second[10], scale);
          bright  = beat.word_second[15:12];
          track_counter = pc + 12'd2;
        end
      endcase
    end
    seg.next_address = track_counter;
    seg.beam_on      = (bright != 4'd0);
    seg.to_x         = track_x;
    seg.to_y         = track_y;
    seg.intensity    = bright;
    seg.halted       = !track_running;
    seg.stack_fault  = fault;
    return seg;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  function automatic vdlp_pkg::in_beat_t exec_beat(input logic [15:0] w1,
                                                   input logic [15:0] w2);
    vdlp_pkg::in_beat_t beat;
    beat.command       = vdlp_pkg::CMD_EXEC;
    beat.start_address = 12'($urandom);
    beat.word_first    = w1;
    beat.word_second   = w2;
    return beat;
  endfunction

  function automatic vdlp_pkg::in_beat_t start_beat(input logic [11:0] addr);
    vdlp_pkg::in_beat_t beat;
    beat.command       = vdlp_pkg::CMD_START;
    beat.start_address = addr;
    beat.word_first    = 16'($urandom);
    beat.word_second   = 16'($urandom);
    return beat;
  endfunction

  // Present one beat, hold it until accepted, then record its prediction.
  // Valid is only lowered when an idle cycle is inserted, so it never gets
  // two updates in the same step.
  task automatic send_beat(input vdlp_pkg::in_beat_t beat);
    if (!quiet_stretch) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    expected_segments.push_back(trace_segment(beat));
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Stall the result channel on about ten percent of cycles, never in a quiet stretch.
  always @(posedge clk) begin
    if (quiet_stretch) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    vdlp_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_segments.size() == 0) begin
        $error("result beat with no prediction waiting: %0h", out_data);
        error_count++;
      end else begin
        want = expected_segments.pop_front();
        check_field("next_address", 16'(want.next_address), 16'(out_data.next_address));
        check_field("beam_on", 16'(want.beam_on), 16'(out_data.beam_on));
        check_field("from_x", want.from_x, out_data.from_x);
        check_field("from_y", want.from_y, out_data.from_y);
        check_field("to_x", want.to_x, out_data.to_x);
        check_field("to_y", want.to_y, out_data.to_y);
        check_field("intensity", 16'(want.intensity), 16'(out_data.intensity));
        check_field("halted", 16'(want.halted), 16'(out_data.halted));
        check_field("stack_fault", 16'(want.stack_fault), 16'(out_data.stack_fault));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Instructions before any start must be dropped with halted set.
  task automatic test_ignored_while_halted();
    send_beat(exec_beat(16'h07FF, 16'hF7FF));
    send_beat(exec_beat({vdlp_pkg::OP_JSRL, 12'hABC}, 16'hFFFF));
  endtask

  // Long vectors at the scale extremes, absolute moves and counter wrap.
  task automatic test_long_vectors();
    send_beat(start_beat(12'h000));
    // Scale 15 + 0: largest left shift, full brightness
    send_beat(exec_beat(16'h03FF, 16'hF3FF));
    // Scale 15 + 9 wraps to 8: right by one, both deltas negative, blanked
    send_beat(exec_beat(16'h97FF, 16'h07FF));
    // Absolute move with sign bits set, global scale to 0
    send_beat(exec_beat({vdlp_pkg::OP_LABS, 12'hFFF}, 16'h0FFF));
    // Scale 0 + 9: unity
    send_beat(exec_beat(16'h95A5, 16'h8A5A));
    // Scale 0 + 0: right by nine, negative zero on x
    send_beat(exec_beat(16'h03FF, 16'h1400));
    // Back to scale 15 at the origin
    send_beat(exec_beat({vdlp_pkg::OP_LABS, 12'h000}, 16'hF000));
    // Top address: counter wraps past the end
    send_beat(start_beat(12'hFFF));
    send_beat(exec_beat(16'h0155, 16'h72AA));
  endtask

  // Short vectors over all four short scales and both signs.
  task automatic test_short_vectors();
    send_beat(exec_beat(16'hF000, 16'hFFFF));
    send_beat(exec_beat(16'hFFFF, 16'h0000));
    send_beat(exec_beat(16'hF75A, 16'hFFFF));
    send_beat(exec_beat(16'hF8A5, 16'h0000));
  endtask

  // Fill the return stack, overflow it, unwind it, underflow it, then jump.
  task automatic test_subroutines();
    send_beat(exec_beat({vdlp_pkg::OP_JSRL, 12'h123}, 16'hFFFF));
    send_beat(exec_beat({vdlp_pkg::OP_JSRL, 12'hFFF}, 16'h0000));
    send_beat(exec_beat({vdlp_pkg::OP_JSRL, 12'h000}, 16'hFFFF));
    send_beat(exec_beat({vdlp_pkg::OP_JSRL, 12'h800}, 16'h0000));
    send_beat(exec_beat({vdlp_pkg::OP_JSRL, 12'h555}, 16'hFFFF));
    for (int i = 0; i < STACK_DEPTH + 1; i++) begin
      send_beat(exec_beat({vdlp_pkg::OP_RTSL, 12'(i * 12'h333)}, 16'(i * 16'h3333)));
    end
    send_beat(exec_beat({vdlp_pkg::OP_JMPL, 12'hFFF}, 16'hFFFF));
  endtask

  // Halt, then check that the next instruction is dropped.
  task automatic test_halt();
    send_beat(exec_beat({vdlp_pkg::OP_HALT, 12'hFFF}, 16'hFFFF));
    send_beat(exec_beat(16'hFFFF, 16'hFFFF));
  endtask

  // Random programs: mostly running instruction streams with a weighted
  // opcode mix, the odd restart, and noise beats while halted.
  task automatic test_random_programs();
    int unsigned        taken;
    int unsigned        pick;
    logic [3:0]         op;
    vdlp_pkg::in_beat_t beat;
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      quiet_stretch <= (taken >= 400 && taken < 700);
      beat  = exec_beat(16'($urandom), 16'($urandom));
      pick  = $urandom_range(99);
      if (!track_running) begin
        if (pick < 85) begin
          beat = start_beat(12'($urandom));
        end
      end else if (pick < 3) begin
        beat = start_beat(12'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          op = 4'($urandom_range(9));
        end else if (pick < 50) begin
          op = vdlp_pkg::OP_LABS;
        end else if (pick < 53) begin
          op = vdlp_pkg::OP_HALT;
        end else if (pick < 65) begin
          op = vdlp_pkg::OP_JSRL;
        end else if (pick < 77) begin
          op = vdlp_pkg::OP_RTSL;
        end else if (pick < 84) begin
          op = vdlp_pkg::OP_JMPL;
        end else begin
          op = vdlp_pkg::OP_SVEC;
        end
        beat.word_first[15:12] = op;
      end
      // Count only beats the block acts on
      if (beat.command == vdlp_pkg::CMD_START || track_running) begin
        taken++;
      end
      send_beat(beat);
    end
    quiet_stretch <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    clear_tracking();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_while_halted();
    test_long_vectors();
    test_short_vectors();
    test_subroutines();
    test_halt();
    test_random_programs();

    // Drop valid, drain the pipeline, then let the bench settle
    in_valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a hung handshake or missing result ends the run here
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/vdlp_pkg.sv
sv/vector_display_list_processor.sv
sv/vdlp_checker.sv
test/tb_vector_display_list_processor.sv
